@@ design/clock_page_replacement_with_age_top_macros.svh @@
// Assertion macros for the clock page replacement block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef CLOCK_PAGE_REPLACEMENT_WITH_AGE_TOP_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_WITH_AGE_TOP_MACROS_SVH

// clocked, reset-gated assertion
`define CPRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// non-overlapping implication of post on pre
`define CPRA_ASSERT_NEXT(lbl, pre, post, msg) \
  `CPRA_ASSERT(lbl, (pre) |=> (post), msg)

`endif

@@ design/cpra_pkg.sv @@
// Package for the clock page replacement block: sizes, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpra_pkg;

  localparam int FRAME_COUNT = 64;
  localparam int PAGE_SHIFT  = 12;

  localparam int ADDR_W      = 32;
  localparam int PAGE_W      = ADDR_W - PAGE_SHIFT;
  localparam int TICK_W      = 32;
  localparam int IDX_W       = $clog2(FRAME_COUNT);
  localparam int FRAME_IDX_W = 6;
  localparam int OLD_PAGE_W  = 20;
  localparam int AGE_W       = 16;
  localparam int SKIP_W      = 6;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_W       = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HAND_SKIP = 8'd1;

  localparam logic [AGE_W-1:0]  AGE_LIMIT_RST = 16'd500;
  localparam logic [SKIP_W-1:0] HAND_SKIP_RST = 6'd3;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_SWEEP    = 3'd2;
  localparam logic [2:0] ST_FALLBACK = 3'd3;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [PAGE_W-1:0] page;
    logic [TICK_W-1:0] stamp;
  } frame_wr_t;

endpackage

`default_nettype wire

@@ design/cpra_frame_store.sv @@
// Frame store: page and stamp memories with per-frame valid bits.
// Unwritten frames read as page 0, stamp 0. Depends on cpra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpra_frame_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cpra_pkg::IDX_W-1:0]    rd_addr_i,
  input  cpra_pkg::frame_wr_t           wr_i,
  output logic [cpra_pkg::PAGE_W-1:0]   rd_page_o,
  output logic [cpra_pkg::TICK_W-1:0]   rd_stamp_o
);
  import cpra_pkg::*;

  logic [PAGE_W-1:0]      page_mem  [FRAME_COUNT];
  logic [TICK_W-1:0]      stamp_mem [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] valid_q;
  logic                   rd_valid_q;
  logic [PAGE_W-1:0]      rd_page_q;
  logic [TICK_W-1:0]      rd_stamp_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      page_mem[wr_i.addr]  <= wr_i.page;
      stamp_mem[wr_i.addr] <= wr_i.stamp;
    end
    rd_page_q  <= page_mem[rd_addr_i];
    rd_stamp_q <= stamp_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) valid_q[wr_i.addr] <= 1'b1;
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_page_o  = rd_valid_q ? rd_page_q  : '0;
  assign rd_stamp_o = rd_valid_q ? rd_stamp_q : '0;

endmodule

`default_nettype wire

@@ design/clock_page_replacement_with_age_top.sv @@
// Clock page replacement with age stamps: top level and sequencer.
// Depends on cpra_pkg and cpra_frame_store.
//
//  channel  | dir | fields (low bit up)
//  s_axis   | in  | tdata: address[31:0]
//  m_axis   | out | tdata: hit[0], frame_index[6:1], old_page[26:7], zero fill
//  cfg      | in  | index 0 age_limit, index 1 hand_skip, others ignored
//
// One frame is examined per cycle through one compare/subtract unit fed by a
// single registered memory read port: a hit scan over up to 64 frames, then a
// sweep over up to 64 frames, then a fallback that takes the frame at the hand.
// Input is held off until the result has been taken. Reset is asynchronous;
// frames start as page 0, stamp 0, via valid bits (no clearing pass).
`timescale 1ns / 1ps
`default_nettype none

module clock_page_replacement_with_age_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cpra_pkg::ADDR_W-1:0]       s_axis_tdata,   // address
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cpra_pkg::OUT_W-1:0]        m_axis_tdata,   // hit, frame_index, old_page
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cpra_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cpra_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import cpra_pkg::*;

  localparam int SUM_W = ((IDX_W > SKIP_W) ? IDX_W : SKIP_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

  logic [2:0]             state_q, state_d;
  logic [IDX_W-1:0]       hand_q, hand_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;
  logic [PAGE_W-1:0]      page_q, page_d;
  logic [TICK_W-1:0]      tick_q, tick_d;
  logic [FRAME_COUNT-1:0] ref_q, ref_d;
  logic [AGE_W-1:0]       age_limit_q;
  logic [SKIP_W-1:0]      hand_skip_q;

  logic                   out_valid_q, out_valid_d;
  logic                   out_hit_q, out_hit_d;
  logic [FRAME_IDX_W-1:0] out_idx_q, out_idx_d;
  logic [OLD_PAGE_W-1:0]  out_old_q, out_old_d;

  logic [IDX_W-1:0]       hand_inc;
  logic [IDX_W-1:0]       rd_addr;
  logic [PAGE_W-1:0]      rd_page;
  logic [TICK_W-1:0]      rd_stamp;
  logic [TICK_W-1:0]      age;
  logic [SUM_W-1:0]       skip_sum;
  frame_wr_t              wr;
  logic                   in_fire;

  assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign hand_inc = (hand_q == LAST_IDX) ? '0 : hand_q + 1'b1;
  assign rd_addr  = (state_q == ST_IDLE) ? hand_q : hand_inc;
  assign age      = tick_q - rd_stamp;
  assign skip_sum = SUM_W'(hand_q) + SUM_W'(hand_skip_q);

  cpra_frame_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .wr_i       (wr),
    .rd_page_o  (rd_page),
    .rd_stamp_o (rd_stamp)
  );

  always_comb begin
    state_d     = state_q;
    hand_d      = hand_q;
    cnt_d       = cnt_q;
    page_d      = page_q;
    tick_d      = tick_q;
    ref_d       = ref_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_hit_d   = out_hit_q;
    out_idx_d   = out_idx_q;
    out_old_d   = out_old_q;
    wr.en       = 1'b0;
    wr.addr     = hand_q;
    wr.page     = page_q;
    wr.stamp    = TICK_W'(1);

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          page_d  = s_axis_tdata[ADDR_W-1:PAGE_SHIFT];
          tick_d  = tick_q + 1'b1;
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_page == page_q) begin
          wr.en          = 1'b1;
          wr.stamp       = tick_q;
          ref_d[hand_q]  = 1'b1;
          out_valid_d    = 1'b1;
          out_hit_d      = 1'b1;
          out_idx_d      = FRAME_IDX_W'(hand_q);
          out_old_d      = OLD_PAGE_W'(page_q);
          state_d        = ST_IDLE;
        end else begin
          hand_d = hand_inc;
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q == LAST_IDX) begin
            cnt_d   = '0;
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (!ref_q[hand_q] && (age > TICK_W'(age_limit_q))) begin
          wr.en         = 1'b1;
          ref_d[hand_q] = 1'b1;
          out_valid_d   = 1'b1;
          out_hit_d     = 1'b0;
          out_idx_d     = FRAME_IDX_W'(hand_q);
          out_old_d     = OLD_PAGE_W'(rd_page);
          state_d       = ST_IDLE;
        end else begin
          ref_d[hand_q] = 1'b0;
          hand_d        = hand_inc;
          cnt_d         = cnt_q + 1'b1;
          if (cnt_q == LAST_IDX) begin
            cnt_d   = '0;
            state_d = ST_FALLBACK;
          end
        end
      end
      ST_FALLBACK: begin
        wr.en         = 1'b1;
        ref_d[hand_q] = 1'b1;
        hand_d        = IDX_W'(skip_sum % FRAME_COUNT);
        out_valid_d   = 1'b1;
        out_hit_d     = 1'b0;
        out_idx_d     = FRAME_IDX_W'(hand_q);
        out_old_d     = OLD_PAGE_W'(rd_page);
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hand_q      <= '0;
      cnt_q       <= '0;
      tick_q      <= '0;
      ref_q       <= '0;
      out_valid_q <= 1'b0;
      age_limit_q <= AGE_LIMIT_RST;
      hand_skip_q <= HAND_SKIP_RST;
    end else begin
      state_q     <= state_d;
      hand_q      <= hand_d;
      cnt_q       <= cnt_d;
      tick_q      <= tick_d;
      ref_q       <= ref_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_AGE_LIMIT) age_limit_q <= cfg_data_i[AGE_W-1:0];
        if (cfg_index_i == CFG_HAND_SKIP) hand_skip_q <= cfg_data_i[SKIP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q    <= page_d;
    out_hit_q <= out_hit_d;
    out_idx_q <= out_idx_d;
    out_old_q <= out_old_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_old_q, out_idx_q, out_hit_q});

endmodule

`default_nettype wire

@@ design/cpra_checker.sv @@
// Port-level checker for the clock page replacement top level, with its bind.
// Depends on cpra_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "clock_page_replacement_with_age_top_macros.svh"

module cpra_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [cpra_pkg::OUT_W-1:0]        m_axis_tdata
);
  import cpra_pkg::*;

  `CPRA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `CPRA_ASSERT_NEXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result data moved")
  `CPRA_ASSERT(a_no_accept_pending, m_axis_tvalid |-> !s_axis_tready, "input taken with result pending")
  `CPRA_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  `CPRA_ASSERT_NEXT(a_single_result, m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "extra result transaction")

endmodule

bind clock_page_replacement_with_age_top cpra_checker u_cpra_checker (.*);

`default_nettype wire

@@ tb/sv/cpra_access_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the clock page replacement block: keeps its own copy of the frame
// table, predicts every lookup and checks the result stream. Depends on cpra_pkg.

module cpra_access_checker
  import cpra_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [ADDR_W-1:0]     s_data_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [OUT_W-1:0]      m_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_count_o,
  output int                    results_seen_o
);

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame;
    logic [OLD_PAGE_W-1:0]  old_page;
  } lookup_t;

  logic [PAGE_W-1:0] frame_page  [FRAME_COUNT];
  logic [TICK_W-1:0] frame_stamp [FRAME_COUNT];
  logic              frame_ref   [FRAME_COUNT];
  logic [TICK_W-1:0] tick;
  logic [IDX_W-1:0]  hand;
  logic [AGE_W-1:0]  age_limit;
  logic [SKIP_W-1:0] hand_skip;
  lookup_t           pending_lookups [$];

  function automatic lookup_t load_frame(input logic [IDX_W-1:0] idx,
                                         input logic [PAGE_W-1:0] page);
    lookup_t res;
    res.hit         = 1'b0;
    res.frame       = idx;
    res.old_page    = frame_page[idx];
    frame_page[idx] = page;
    frame_ref[idx]  = 1'b1;
    frame_stamp[idx] = 1;
    return res;
  endfunction

  function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] addr);
    logic [PAGE_W-1:0] page;
    logic [IDX_W-1:0]  victim;
    lookup_t           res;
    page = addr[ADDR_W-1:PAGE_SHIFT];
    tick = tick + 1'b1;
    for (int n = 0; n < FRAME_COUNT; n++) begin
      if (frame_page[hand] == page) begin
        frame_stamp[hand] = tick;
        frame_ref[hand]   = 1'b1;
        res.hit      = 1'b1;
        res.frame    = hand;
        res.old_page = page;
        return res;
      end
      hand = hand + 1'b1;
    end
    // second-chance sweep; age is unsigned modulo 2^32
    for (int n = 0; n < FRAME_COUNT; n++) begin
      if (frame_ref[hand]) begin
        frame_ref[hand] = 1'b0;
      end else if ((tick - frame_stamp[hand]) > {{(TICK_W-AGE_W){1'b0}}, age_limit}) begin
        return load_frame(hand, page);
      end
      hand = hand + 1'b1;
    end
    victim = hand;
    res    = load_frame(victim, page);
    hand   = victim + hand_skip;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lookup_t want;
    lookup_t got;
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_COUNT; i++) begin
        frame_page[i]  = '0;
        frame_stamp[i] = '0;
        frame_ref[i]   = 1'b0;
      end
      tick      = '0;
      hand      = '0;
      age_limit = AGE_LIMIT_RST;
      hand_skip = HAND_SKIP_RST;
      pending_lookups.delete();
      mismatch_count_o <= 0;
      results_seen_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_AGE_LIMIT: age_limit = cfg_data_i[AGE_W-1:0];
          CFG_HAND_SKIP: hand_skip = cfg_data_i[SKIP_W-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) pending_lookups.push_back(predict_lookup(s_data_i));
      if (m_valid_i && m_ready_i) begin
        got.hit      = m_data_i[0];
        got.frame    = m_data_i[FRAME_IDX_W:1];
        got.old_page = m_data_i[FRAME_IDX_W+OLD_PAGE_W:FRAME_IDX_W+1];
        results_seen_o <= results_seen_o + 1;
        if (pending_lookups.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: unexpected result hit=%0d frame=%0d old_page=%h",
                     $realtime, got.hit, got.frame, got.old_page);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = pending_lookups.pop_front();
          if (got.hit !== want.hit || got.frame !== want.frame ||
              got.old_page !== want.old_page) begin
            if (mismatch_count_o < 10)
              $display("%0t: lookup mismatch exp hit=%0d frame=%0d old_page=%h, got hit=%0d frame=%0d old_page=%h",
                       $realtime, want.hit, want.frame, want.old_page,
                       got.hit, got.frame, got.old_page);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_clock_page_replacement_with_age_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the clock page replacement block: clock, reset, address and
// register stimulus, result back-pressure and verdict. Depends on cpra_pkg,
// cpra_access_checker and the block itself.

module tb_clock_page_replacement_with_age_top;
  import cpra_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 148;
  localparam int POOL_SIZE    = 128;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 8'hFF;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ADDR_W-1:0]     s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  int mismatch_count;
  int results_seen;
  int items_sent = 0;
  int burst_left = 0;
  int loop_pos   = 0;
  int stall_mode = 0;
  int stall_left = 0;

  logic [PAGE_W-1:0] page_pool [POOL_SIZE];

  // per phase: age limit, hand skip, working set and looping run length
  int phase_age  [PHASES] = '{0, 65535, 20, 1, 300, 65535, 100, 0};
  int phase_skip [PHASES] = '{0, 63, 1, 32, 5, 0, 17, 63};
  int phase_ws   [PHASES] = '{40, 70, 20, 100, 64, 10, 128, 50};
  int phase_loop [PHASES] = '{60, 80, 40, 128, 64, 70, 100, 66};

  clock_page_replacement_with_age_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  cpra_access_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_valid_i        (s_axis_tvalid),
    .s_ready_i        (s_axis_tready),
    .s_data_i         (s_axis_tdata),
    .m_valid_i        (m_axis_tvalid),
    .m_ready_i        (m_axis_tready),
    .m_data_i         (m_axis_tdata),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .results_seen_o   (results_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result back-pressure: one of four patterns, chosen anew after each random run
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= stall_left[2];
    endcase
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_clock_page_replacement_with_age_top: FAIL");
    $finish;
  end

  task automatic send_address(input logic [ADDR_W-1:0] addr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    items_sent++;
  endtask

  // leaves cfg_valid_i high so that writes can follow back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // mostly a hot working set or a cyclic run of pages, some fully random
  function automatic logic [ADDR_W-1:0] next_address(input int ws, input int loop_len);
    int                    sel;
    logic [PAGE_W-1:0]     page;
    logic [PAGE_SHIFT-1:0] offset;
    sel    = $urandom_range(0, 99);
    offset = PAGE_SHIFT'($urandom);
    if (sel >= 85) return $urandom;
    if (sel < 60) begin
      page = page_pool[$urandom_range(0, ws - 1)];
    end else begin
      page = page_pool[loop_pos % loop_len];
      loop_pos++;
    end
    return {page, offset};
  endfunction

  task automatic wait_drained();
    while (results_seen < items_sent) @(posedge clk_i);
  endtask

  initial begin : stimulus
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = PAGE_W'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // page 0 is resident from reset
    send_address(32'h0000_0000);
    send_address(32'h0000_0FFF);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_F000);
    send_address(32'h1234_5678);
    send_address(32'h8000_0000);
    send_address(32'h0000_1000);
    send_address(32'h7FFF_FFFF);
    send_address(32'hAAAA_AAAA);
    send_address(32'h5555_5555);
    send_address(32'h8000_0ABC);
    send_address(32'h0000_0001);
    s_axis_tvalid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_reg(CFG_AGE_LIMIT, 16'(phase_age[p]));
      // upper bits of the skip write are junk and must be dropped
      write_reg(CFG_HAND_SKIP, {10'($urandom), 6'(phase_skip[p])});
      if (p % 2 == 1) write_reg(CFG_NO_REG, 16'($urandom));
      cfg_valid_i <= 1'b0;
      repeat (PHASE_ITEMS) send_address(next_address(phase_ws[p], phase_loop[p]));
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && results_seen == items_sent)
      $display("tb_clock_page_replacement_with_age_top: PASS");
    else
      $display("tb_clock_page_replacement_with_age_top: FAIL");
    $finish;
  end

endmodule

@@ clock_page_replacement_with_age_top.f @@
+incdir+design
design/cpra_pkg.sv
design/cpra_frame_store.sv
design/clock_page_replacement_with_age_top.sv
design/cpra_checker.sv
tb/sv/cpra_access_checker.sv
tb/sv/tb_clock_page_replacement_with_age_top.sv
